### sv/sefr_pkg.sv
package sefr_pkg;

  localparam int FRAME_CAPACITY_DEF = 64;
  localparam int BYTE_W = 8;
  localparam int LEN_W = 6;
  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

  localparam logic [BYTE_W-1:0] MARK_START  = 8'h02;
  localparam logic [BYTE_W-1:0] MARK_END    = 8'h03;
  localparam logic [BYTE_W-1:0] MARK_ESCAPE = 8'h23;
  localparam logic [BYTE_W-1:0] ESCAPE_FLIP = 8'h40;
  localparam logic [BYTE_W-1:0] CHECK_SEED  = 8'hFF;

  typedef enum logic {
    CMD_WRITE,
    CMD_EMIT
  } cmd_kind_t;

  // arg is the store address of a write, or the payload count of an emit
  typedef struct packed {
    cmd_kind_t         kind;
    logic [LEN_W-1:0]  arg;
    logic [BYTE_W-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic [LEN_W-1:0]  payload_length;
    logic              last;
  } out_item_t;

endpackage

### sv/sefr_queue.sv
module sefr_queue
  import sefr_pkg::*;
#(
  parameter type item_t = logic,
  parameter int  DEPTH  = 2,
  localparam int LVL_W  = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  item_t            push_item,
  input  logic             pop,
  output item_t            pop_item,
  output logic [LVL_W-1:0] level
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  item_t            slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_pop;
  logic             do_push;

  assign do_pop   = pop && (level != '0);
  assign do_push  = push && ((level != LVL_W'(DEPTH)) || do_pop);
  assign pop_item = slots[rd_ptr];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) wr_ptr <= ptr_inc(wr_ptr);
      if (do_pop) rd_ptr <= ptr_inc(rd_ptr);
      if (do_push && !do_pop) level <= level + 1'b1;
      else if (do_pop && !do_push) level <= level - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_item;
  end

endmodule

### sv/sefr_front.sv
module sefr_front
  import sefr_pkg::*;
#(
  parameter int FRAME_CAPACITY = FRAME_CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              cmd_full,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              cmd_push,
  output cmd_t              cmd
);

  localparam int PW = $clog2(FRAME_CAPACITY + 1);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DATA,
    PH_ESC
  } phase_t;

  phase_t            phase;
  phase_t            phase_next;
  logic [PW-1:0]     pos;
  logic [PW-1:0]     pos_next;
  logic [BYTE_W-1:0] csum;
  logic [BYTE_W-1:0] csum_next;
  logic              in_fire;
  logic              do_store;
  logic [BYTE_W-1:0] store_val;

  assign in_fire = push && !cmd_full;

  always_comb begin
    phase_next = phase;
    pos_next   = pos;
    csum_next  = csum;
    do_store   = 1'b0;
    store_val  = rx_byte;
    cmd_push   = 1'b0;
    cmd.kind   = CMD_WRITE;
    cmd.arg    = LEN_W'(pos);
    cmd.data   = rx_byte;

    if (in_fire) begin
      if (rx_byte == MARK_START) begin
        pos_next   = '0;
        csum_next  = CHECK_SEED;
        phase_next = PH_DATA;
      end else begin
        case (phase)
          PH_DATA: begin
            if (rx_byte == MARK_END) begin
              phase_next = PH_IDLE;
              if ((pos >= PW'(2)) && (csum == '0)) begin
                pos_next = pos - 1'b1;
                cmd_push = 1'b1;
                cmd.kind = CMD_EMIT;
                cmd.arg  = LEN_W'(pos - 1'b1);
              end
            end else if (rx_byte == MARK_ESCAPE) begin
              phase_next = PH_ESC;
            end else if (rx_byte < MARK_END) begin
              pos_next   = '0;
              csum_next  = CHECK_SEED;
              phase_next = PH_IDLE;
            end else begin
              do_store = 1'b1;
            end
          end
          PH_ESC: begin
            phase_next = PH_DATA;
            do_store   = 1'b1;
            store_val  = (rx_byte == MARK_ESCAPE) ? rx_byte : (rx_byte ^ ESCAPE_FLIP);
          end
          default: begin
            phase_next = PH_DATA;
          end
        endcase
      end

      if (do_store) begin
        if (pos >= PW'(FRAME_CAPACITY)) begin
          // drop the byte on overflow and clear the frame
          pos_next   = '0;
          csum_next  = CHECK_SEED;
          phase_next = PH_IDLE;
        end else begin
          csum_next = csum ^ store_val;
          pos_next  = pos + 1'b1;
          cmd_push  = 1'b1;
          cmd.kind  = CMD_WRITE;
          cmd.arg   = LEN_W'(pos);
          cmd.data  = store_val;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      pos   <= '0;
      csum  <= CHECK_SEED;
    end else begin
      phase <= phase_next;
      pos   <= pos_next;
      csum  <= csum_next;
    end
  end

endmodule

### sv/sefr_back.sv
module sefr_back
  import sefr_pkg::*;
#(
  parameter int FRAME_CAPACITY = FRAME_CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  input  logic      pop,
  output logic      empty,
  output out_item_t out_item
);

  localparam int AW    = $clog2(FRAME_CAPACITY);
  localparam int OLV_W = $clog2(OUT_DEPTH + 1);

  typedef enum logic {
    B_IDLE,
    B_DRAIN
  } bstate_t;

  bstate_t            state;
  logic [LEN_W-1:0]   len;
  logic [LEN_W-1:0]   k;
  logic               pend;
  logic               pend_last;
  logic [BYTE_W-1:0]  rd_data;
  logic [BYTE_W-1:0]  mem [FRAME_CAPACITY];
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;
  logic               mem_we;
  logic               issue;
  logic               last_issue;
  logic               room;
  logic               pop_fire;
  logic [OLV_W-1:0]   out_level;
  out_item_t          push_item;

  assign empty      = (out_level == '0);
  assign pop_fire   = pop && !empty;
  // count the read in flight and the entry leaving this cycle
  assign room       = ((OLV_W + 1)'(out_level) + (OLV_W + 1)'(pend))
                      < ((OLV_W + 1)'(OUT_DEPTH) + (OLV_W + 1)'(pop_fire));
  assign issue      = (state == B_DRAIN) && room;
  assign last_issue = (k == len - 1'b1);
  assign cmd_pop    = (state == B_IDLE) && cmd_valid;
  assign mem_we     = cmd_pop && (cmd.kind == CMD_WRITE);
  assign wr_addr    = AW'(cmd.arg);
  assign rd_addr    = AW'(k);

  assign push_item.payload_byte   = rd_data;
  assign push_item.payload_length = len;
  assign push_item.last           = pend_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      pend  <= 1'b0;
    end else begin
      pend <= issue;
      case (state)
        B_IDLE: begin
          if (cmd_pop && (cmd.kind == CMD_EMIT)) begin
            len   <= cmd.arg;
            k     <= '0;
            state <= B_DRAIN;
          end
        end
        B_DRAIN: begin
          if (issue) begin
            k         <= k + 1'b1;
            pend_last <= last_issue;
            if (last_issue) state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= cmd.data;
    if (issue) rd_data <= mem[rd_addr];
  end

  sefr_queue #(
    .item_t (out_item_t),
    .DEPTH  (OUT_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst       (rst),
    .push      (pend),
    .push_item (push_item),
    .pop       (pop_fire),
    .pop_item  (out_item),
    .level     (out_level)
  );

  a_out_no_overflow: assert property (@(posedge clk) disable iff (rst)
    ((OLV_W + 1)'(out_level) + (OLV_W + 1)'(pend)) <= (OLV_W + 1)'(OUT_DEPTH))
    else $error("output queue overrun");

  a_drain_len: assert property (@(posedge clk) disable iff (rst)
    (state == B_DRAIN) |-> (len != '0))
    else $error("drain started with zero length");

  a_no_cmd_in_drain: assert property (@(posedge clk) disable iff (rst)
    (state == B_DRAIN) |-> !cmd_pop)
    else $error("command taken during drain");

  a_drain_ends: assert property (@(posedge clk) disable iff (rst)
    (issue && last_issue) |=> (state == B_IDLE) && pend && pend_last)
    else $error("drain did not end on final byte");

endmodule

### sv/stx_etx_frame_receiver_top.sv
// Path: the emit command of a good frame passes through the command queue, the back
//   drain state, the store read register and the output queue to the result ports.
// Throughput: one byte per cycle while the command queue has room; a frame drains
//   from the frame store at one store read a cycle while the output queue has room.
// Reset: synchronous; phase idle, position 0, checksum 0xFF, both queues empty.
//   The frame store is not cleared; only written entries are ever read.
module stx_etx_frame_receiver_top
  import sefr_pkg::*;
#(
  parameter int FRAME_CAPACITY = FRAME_CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              empty,
  input  logic              pop,
  output logic [BYTE_W-1:0] payload_byte,
  output logic [LEN_W-1:0]  payload_length,
  output logic              last
);

  localparam int CLV_W = $clog2(CMD_DEPTH + 1);

  // front to queue
  logic             cmd_push;
  cmd_t             cmd_in;
  // queue to back
  cmd_t             cmd_out;
  logic             cmd_pop;
  logic [CLV_W-1:0] cmd_level;
  logic             cmd_valid;
  out_item_t        out_item;

  // Hold off input while the command queue is full; every byte may need a slot.
  assign full      = (cmd_level == CLV_W'(CMD_DEPTH));
  assign cmd_valid = (cmd_level != '0);

  // Front: unstuff, track phase, position and checksum, and issue store writes
  // and frame emits. Bytes that only change phase or clear leave no command.
  sefr_front #(
    .FRAME_CAPACITY (FRAME_CAPACITY)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .cmd_full (full),
    .rx_byte  (rx_byte),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  // Decouple the two halves so bytes keep arriving while a frame drains.
  sefr_queue #(
    .item_t (cmd_t),
    .DEPTH  (CMD_DEPTH)
  ) u_cmd_q (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_item (cmd_in),
    .pop       (cmd_pop),
    .pop_item  (cmd_out),
    .level     (cmd_level)
  );

  // Back: own the frame store, apply writes in order and drain emitted frames.
  // Writes queued behind an emit wait until that frame has been read out.
  sefr_back #(
    .FRAME_CAPACITY (FRAME_CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .pop       (pop),
    .empty     (empty),
    .out_item  (out_item)
  );

  assign payload_byte   = out_item.payload_byte;
  assign payload_length = out_item.payload_length;
  assign last           = out_item.last;

endmodule
